@@ hw/rtl/kmt_pkg.sv @@
package kmt_pkg;

  // table geometry
  localparam int SLOT_COUNT = 256;
  localparam int IDX_W      = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  // operation codes
  localparam logic OP_RECORD  = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  // input item
  typedef struct packed {
    logic        operation;
    logic [15:0] key;
    logic [63:0] region_address;
    logic [31:0] region_length;
  } in_t;

  // result item
  typedef struct packed {
    logic        accepted;
    logic        freed_valid;
    logic [63:0] freed_address;
    logic [31:0] freed_length;
  } out_t;

  // one stored slot entry
  typedef struct packed {
    logic [15:0] key;
    logic [63:0] address;
    logic [31:0] length;
  } slot_t;

  localparam int SLOT_W = $bits(slot_t);

  // handshake between the scan controller and the output stage
  typedef struct packed {
    logic valid;
    out_t data;
  } res_t;

endpackage

@@ hw/rtl/kmt_ram.sv @@
module kmt_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 112,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hw/rtl/kmt_ctrl.sv @@
module kmt_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 item_valid,
  output logic                 item_stall,
  input  kmt_pkg::in_t         item,
  output kmt_pkg::res_t        res,
  input  logic                 res_take,
  output logic                 ram_we,
  output logic [kmt_pkg::IDX_W-1:0] ram_waddr,
  output logic [kmt_pkg::SLOT_W-1:0] ram_wdata,
  output logic                 ram_re,
  output logic [kmt_pkg::IDX_W-1:0] ram_raddr,
  input  logic [kmt_pkg::SLOT_W-1:0] ram_rdata
);
  import kmt_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_t;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);

  state_t                  state_r;
  in_t                     item_r;
  out_t                    res_r;
  logic [SLOT_COUNT-1:0]   valid_r;
  logic [IDX_W-1:0]        iss_idx_r;
  logic                    iss_end_r;
  logic                    chk_vld_r;
  logic [IDX_W-1:0]        chk_idx_r;
  logic                    have_empty_r;
  logic [IDX_W-1:0]        empty_idx_r;

  slot_t                   rd_slot;
  logic                    issuing;
  logic                    is_rec;
  logic                    chk_slot_vld;
  logic                    hit;
  logic                    chk_last;
  logic                    empty_found;
  logic [IDX_W-1:0]        empty_idx;
  logic                    in_bad;
  logic                    in_xfer;

  // read side of the scan
  assign issuing   = (state_r == S_SCAN) && !iss_end_r;
  assign ram_re    = issuing;
  assign ram_raddr = iss_idx_r;
  assign rd_slot   = slot_t'(ram_rdata);

  // compare the slot read last cycle
  assign is_rec       = (item_r.operation == OP_RECORD);
  assign chk_slot_vld = chk_vld_r && valid_r[chk_idx_r];
  assign hit          = (state_r == S_SCAN) && chk_slot_vld && (rd_slot.key == item_r.key);
  assign chk_last     = (state_r == S_SCAN) && chk_vld_r && (chk_idx_r == LAST_IDX);

  // lowest empty slot seen so far, this one included
  assign empty_found = have_empty_r || (chk_vld_r && !valid_r[chk_idx_r]);
  assign empty_idx   = have_empty_r ? empty_idx_r : chk_idx_r;

  // slot write for a replace or an insert
  assign ram_we    = is_rec && (hit || (chk_last && empty_found));
  assign ram_waddr = hit ? chk_idx_r : empty_idx;
  assign ram_wdata = SLOT_W'({item_r.key, item_r.region_address, item_r.region_length});

  // input side
  assign item_stall = (state_r != S_IDLE);
  assign in_xfer    = item_valid && (state_r == S_IDLE);
  assign in_bad     = (item.operation == OP_RECORD) &&
                      ((item.region_address == 64'd0) || (&item.region_address) ||
                       (item.region_length == 32'd0));

  assign res.valid = (state_r == S_DONE);
  assign res.data  = res_r;

  // sequencer, valid bits and result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      valid_r      <= '0;
      iss_end_r    <= 1'b0;
      chk_vld_r    <= 1'b0;
      have_empty_r <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_xfer) begin
            item_r       <= item;
            iss_idx_r    <= '0;
            iss_end_r    <= 1'b0;
            chk_vld_r    <= 1'b0;
            have_empty_r <= 1'b0;
            res_r        <= '0;
            state_r      <= in_bad ? S_DONE : S_SCAN;
          end
        end
        S_SCAN: begin
          chk_vld_r <= issuing;
          chk_idx_r <= iss_idx_r;
          if (issuing) begin
            if (iss_idx_r == LAST_IDX) begin
              iss_end_r <= 1'b1;
            end else begin
              iss_idx_r <= iss_idx_r + 1'b1;
            end
          end
          if (chk_vld_r && !valid_r[chk_idx_r] && !have_empty_r) begin
            have_empty_r <= 1'b1;
            empty_idx_r  <= chk_idx_r;
          end
          if (hit) begin
            res_r.accepted      <= is_rec;
            res_r.freed_valid   <= 1'b1;
            res_r.freed_address <= rd_slot.address;
            res_r.freed_length  <= rd_slot.length;
            if (!is_rec) begin
              valid_r[chk_idx_r] <= 1'b0;
            end
            state_r <= S_DONE;
          end else if (chk_last) begin
            if (is_rec && empty_found) begin
              res_r.accepted     <= 1'b1;
              valid_r[empty_idx] <= 1'b1;
            end
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (res_take) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ hw/rtl/keyed_mapping_table.sv @@
// keyed_mapping_table: a table of SLOT_COUNT slots mapping a 16-bit key to a
// region (64-bit address, 32-bit length).
// input channel in_valid/in_stall/in_data carries a record or release request;
// the output channel out_valid/out_stall/out_data returns exactly one result
// per request, in request order.
// each request is handled by a linear scan of the slot memory, one slot read
// per cycle through its single registered read port. a request that matches
// slot k completes once slot k has been read and compared; a miss, an insert
// or a full table takes the whole scan. a record with a bad region skips the
// scan and completes without reading the slot memory.
// one request is in work at a time: in_stall is high from transfer until the
// result has been handed to the output register.
// the output register holds a finished result while out_stall is high, and
// the next request is accepted in the meantime; its result waits in the
// controller until the output register frees.
// a synchronous reset (rst_n low) empties the table at once through per-slot
// valid bits and drops any request or result in flight.
module keyed_mapping_table (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  kmt_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output kmt_pkg::out_t out_data
);
  import kmt_pkg::*;

  res_t              res;
  logic              res_take;
  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  logic [SLOT_W-1:0] ram_wdata;
  logic              ram_re;
  logic [IDX_W-1:0]  ram_raddr;
  logic [SLOT_W-1:0] ram_rdata;
  logic              out_valid_r;
  out_t              out_data_r;

  // slot key, address and length storage
  kmt_ram #(
    .DEPTH (SLOT_COUNT),
    .WIDTH (SLOT_W),
    .AW    (IDX_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // scan controller
  kmt_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (in_valid),
    .item_stall (in_stall),
    .item       (in_data),
    .res        (res),
    .res_take   (res_take),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata),
    .ram_re     (ram_re),
    .ram_raddr  (ram_raddr),
    .ram_rdata  (ram_rdata)
  );

  // output register, loads when empty or being drained
  assign res_take = res.valid && (!out_valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_data_r <= res.data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
